// File: rtl/bcdd_pkg.sv
// ---------------------------------------------------------------------------
// bcdd_pkg
// Shared types and constants for the binary to BCD converter with display
// enable.
// ---------------------------------------------------------------------------
package bcdd_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int VALUE_W    = 32;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int OUT_DIGITS = 8;
  localparam int CNT_W      = $clog2(VALUE_W);

  function automatic logic [63:0] max_value_f();
    logic [63:0] m;
    m = 64'd1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      m = m * 64'd10;
    end
    return m - 64'd1;
  endfunction

  // largest value shown without saturation: all nines
  localparam logic [63:0] MAX_VALUE = max_value_f();

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
  } ctrl_t;

endpackage

// File: rtl/bcdd_step.sv
// ---------------------------------------------------------------------------
// bcdd_step
// One shift-add-3 iteration: correct every digit that is 5 or more, then
// shift the BCD word left by one, taking in the next binary bit.
// ---------------------------------------------------------------------------
module bcdd_step
  import bcdd_pkg::*;
(
  input  logic [BCD_W-1:0] bcd_in,
  input  logic             bit_in,
  output logic [BCD_W-1:0] bcd_out
);

  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_in[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_in[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_in[4*k +: 4];
      end
    end
  end

  assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule

// File: rtl/bcdd_ctrl.sv
// ---------------------------------------------------------------------------
// bcdd_ctrl
// Sequencer: takes a request, runs one shift step per input bit, then
// emits the result.
// ---------------------------------------------------------------------------
module bcdd_ctrl
  import bcdd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output ctrl_t ctrl
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      ST_IDLE: begin
        count_next = '0;
        if (start) state_next = ST_CONV;
      end
      ST_CONV: begin
        count_next = count + 1'b1;
        if (count == CNT_W'(VALUE_W - 1)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      ST_CONV: ctrl.shift = 1'b1;
      ST_EMIT: ctrl.emit  = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: rtl/bcd_digits_with_display_enable.sv
// ---------------------------------------------------------------------------
// bcd_digits_with_display_enable
// Binary to packed BCD with leading-zero blanking and saturation.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request is a
// load, one shift-add-3 step per bit of the 32-bit input through a single
// shared digit-correction unit, and one more step to form the enable
// mask. The result appears for exactly one cycle with done high, in the first
// cycle that busy is low again; the receiver cannot stall it, so capture it
// then. A new request may be issued in that same cycle. Values above the
// largest NUM_DIGITS-digit number show as all nines with overflow set; zero
// shows with all displays off (digit_enable_n all ones).
module bcd_digits_with_display_enable
  import bcdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] bcd_digits,
  output logic [7:0]  digit_enable_n,
  output logic        overflow
);

  ctrl_t              ctrl;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd, bcd_step_out;
  logic               ovf;
  logic               sat;
  logic [31:0]        digits_next;
  logic [7:0]         enable_n_next;

  bcdd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  bcdd_step u_step (
    .bcd_in  (bcd),
    .bit_in  (bin[VALUE_W-1]),
    .bcd_out (bcd_step_out)
  );

  assign sat = {32'd0, value} > MAX_VALUE;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= sat ? MAX_VALUE[VALUE_W-1:0] : value;
      ovf <= sat;
      bcd <= '0;
    end else if (ctrl.shift) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= bcd_step_out;
    end
  end

  // digit k is lit when it or any digit above it is nonzero
  for (genvar k = 0; k < OUT_DIGITS; k++) begin : g_out
    if (k < NUM_DIGITS) begin : g_used
      assign digits_next[4*k +: 4] = bcd[4*k +: 4];
      assign enable_n_next[k]      = ~(|bcd[BCD_W-1:4*k]);
    end else begin : g_unused
      assign digits_next[4*k +: 4] = 4'd0;
      assign enable_n_next[k]      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      bcd_digits     <= digits_next;
      digit_enable_n <= enable_n_next;
      overflow       <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_zero_dark: assert property (@(posedge clk) disable iff (rst)
    (done && bcd_digits == 32'd0 && !overflow) |-> digit_enable_n == 8'hFF)
    else $error("zero result with a display lit");

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the binary to BCD converter with display enable. Requests carry a
// 32-bit value. Each one is predicted into packed digits, an active-low
// display mask and an overflow flag, and every strobed result is compared
// against the oldest open prediction. The stimulus is a directed set of
// boundary values followed by random values with random idle bursts.
// ---------------------------------------------------------------------------
module testbench;
  import bcdd_pkg::*;

  localparam int N_RANDOM    = 1250;
  localparam int N_STEADY    = 150;   // last requests sent back to back
  localparam int QUIET_LIMIT = 1000;  // cycles with no request taken and no result
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [31:0] digits;
    logic [7:0]  enable_n;
    logic        ovf;
  } shown_t;

  class display_scoreboard;
    shown_t open_displays[$];
    int     mismatches;

    function new();
      mismatches = 0;
    endfunction

    // decimal digits of the value, saturated to all nines over NUM_DIGITS
    function shown_t convert(logic [31:0] raw);
      logic [63:0] limit;
      logic [63:0] rest;
      logic [63:0] packed_digits;
      logic [15:0] lit;
      shown_t      r;
      limit = 64'd1;
      for (int k = 0; k < NUM_DIGITS; k++) limit = limit * 64'd10;
      limit = limit - 64'd1;
      rest  = {32'd0, raw};
      r.ovf = 1'b0;
      if (rest > limit) begin
        rest  = limit;
        r.ovf = 1'b1;
      end
      packed_digits = '0;
      lit = '0;
      for (int k = 0; k < NUM_DIGITS && k < 16 && rest != 0; k++) begin
        packed_digits = packed_digits | ((rest % 64'd10) << (4 * k));
        lit[k] = 1'b1;
        rest = rest / 64'd10;
      end
      r.digits   = packed_digits[31:0];
      r.enable_n = ~lit[7:0];
      return r;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void log_request(logic [31:0] raw);
      open_displays.push_back(convert(raw));
    endfunction

    task check_result(logic [31:0] digits, logic [7:0] enable_n, logic ovf);
      shown_t want;
      if (open_displays.size() == 0) begin
        report($sformatf("result %h/%h/%b with no request open",
                         digits, enable_n, ovf));
      end else begin
        want = open_displays.pop_front();
        if (digits !== want.digits)
          report($sformatf("bcd_digits %h, want %h", digits, want.digits));
        if (enable_n !== want.enable_n)
          report($sformatf("digit_enable_n %h, want %h", enable_n, want.enable_n));
        if (ovf !== want.ovf)
          report($sformatf("overflow %b, want %b", ovf, want.ovf));
      end
    endtask

    function int outstanding();
      return open_displays.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] value;
  logic        done;
  logic [31:0] bcd_digits;
  logic [7:0]  digit_enable_n;
  logic        overflow;

  display_scoreboard sb = new();
  int quiet_cycles;

  bcd_digits_with_display_enable dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .done(done),
    .bcd_digits(bcd_digits),
    .digit_enable_n(digit_enable_n),
    .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request/result monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (start === 1'b1 && busy === 1'b0) begin
        sb.log_request(value);
        quiet_cycles = 0;
      end
      if (done === 1'b1) begin
        sb.check_result(bcd_digits, digit_enable_n, overflow);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pow10(int n);
    logic [31:0] p;
    p = 32'd1;
    for (int k = 0; k < n; k++) p = p * 32'd10;
    return p;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned sel;
    int          d;
    logic [31:0] p;
    sel = $urandom_range(0, 9);
    d   = $urandom_range(1, 8);
    p   = pow10(d);
    case (sel)
      0, 1, 2, 3: return $urandom % p;                          // values of up to d digits
      4:          return 32'd99999999 + $urandom_range(0, 20) - 32'd10;
      5:          return p + $urandom_range(0, 2) - 32'd1;     // around a power of ten
      default:    return $urandom;
    endcase
  endfunction

  // hold the request up until the block takes it
  task send(logic [31:0] v);
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // start low, value wanders meanwhile; n sets the length of the gap
  task idle(int n);
    @(negedge clk);
    start <= 1'b0;
    value <= $urandom;
    repeat (n - 1) @(negedge clk) value <= $urandom;
  endtask

  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  logic [31:0] directed[] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000, 32'd10000,
    32'd100000, 32'd999999, 32'd1000000, 32'd9999999, 32'd10000000,
    32'd12345678, 32'd99999998, 32'd99999999, 32'd100000000,
    32'd100000001, 32'h7FFFFFFF, 32'h80000000, 32'h55555555,
    32'hAAAAAAAA, 32'hFFFFFFFF
  };

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed[i]) send(directed[i]);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i < N_RANDOM - N_STEADY) begin
        if ($urandom_range(0, 99) == 0) drain();
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) idle($urandom_range(1, 11));
        end
      end
      send(pick_value());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
